### rtl/zone_state_debounce_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Zone state debounce table - assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ZONE_STATE_DEBOUNCE_TABLE_UNIT_MACROS_SVH
`define ZONE_STATE_DEBOUNCE_TABLE_UNIT_MACROS_SVH

// Consequent checked in the same cycle.
`define ZSDT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zsdt assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ZSDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zsdt assertion failed");

`endif

### rtl/zsdt_pkg.sv
// ----------------------------------------------------------------------------
// Zone state debounce table - package
// Item types, table entry layout, operation codes and defaults.
// ----------------------------------------------------------------------------
package zsdt_pkg;

    localparam int NUM_ZONES_DEF      = 32;
    localparam int NUM_PARTITIONS_DEF = 16;

    localparam logic [7:0] CONFIRM_RESET = 8'd3;

    localparam logic [2:0] OP_OBSERVE   = 3'd0;
    localparam logic [2:0] OP_LOAD      = 3'd1;
    localparam logic [2:0] OP_SET_STATE = 3'd2;
    localparam logic [2:0] OP_PARTITION = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;

    // register index taken from paddr[2]
    localparam logic REG_CONFIRM_COUNT = 1'b0;

    typedef struct packed {
        logic [2:0]  op;
        logic [4:0]  zone;
        logic [2:0]  state_value;
        logic [3:0]  partition_index;
        logic        member;
        logic [15:0] load_mask;
        logic [7:0]  load_type;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  confirmed_state;
        logic [7:0]  zone_kind;
        logic [15:0] mask_out;
        logic        in_partition;
        logic        state_changed;
    } result_t;

    typedef struct packed {
        logic [2:0]  cur;
        logic [2:0]  pend;
        logic [7:0]  count;
        logic [7:0]  kind;
        logic [15:0] mask;
    } entry_t;

    typedef struct packed {
        logic   en;
        entry_t data;
    } wr_t;

    localparam entry_t ENTRY_RESET = '{cur: 3'd0, pend: 3'd0, count: CONFIRM_RESET,
                                       kind: 8'd0, mask: 16'd0};

endpackage

### rtl/zsdt_cfg.sv
// ----------------------------------------------------------------------------
// Zone state debounce table - configuration register
// APB-style access to the confirm count register.
// ----------------------------------------------------------------------------
module zsdt_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  confirm_count
);

    logic [7:0] confirm_count_reg;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == zsdt_pkg::REG_CONFIRM_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_count_reg <= zsdt_pkg::CONFIRM_RESET;
        end
        else if (wr_hit)
        begin
            confirm_count_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            zsdt_pkg::REG_CONFIRM_COUNT: prdata = {24'd0, confirm_count_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    assign confirm_count = confirm_count_reg;

endmodule

### rtl/zsdt_table.sv
// ----------------------------------------------------------------------------
// Zone state debounce table - zone store
// Synchronous entry memory with per-entry valid bits and write forwarding.
// ----------------------------------------------------------------------------
`include "zone_state_debounce_table_unit_macros.svh"

module zsdt_table #(
    parameter  int NUM_ZONES = zsdt_pkg::NUM_ZONES_DEF,
    localparam int ZW        = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [ZW-1:0]    rd_addr,
    input  zsdt_pkg::wr_t    wr,
    input  logic [ZW-1:0]    wr_addr,
    output zsdt_pkg::entry_t rd_entry
);

    zsdt_pkg::entry_t     mem [NUM_ZONES];
    zsdt_pkg::entry_t     rdata_reg;
    logic [ZW-1:0]        rd_addr_reg;
    logic [NUM_ZONES-1:0] valid_reg;
    logic                 fwd_en_reg;
    logic [ZW-1:0]        fwd_addr_reg;
    zsdt_pkg::entry_t     fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg   <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fwd_en_reg <= 1'b0;
        end
        else
        begin
            fwd_en_reg <= wr.en;
            if (wr.en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // write landing on the read edge bypasses the stale memory data
    always_comb
    begin
        if (fwd_en_reg && (fwd_addr_reg == rd_addr_reg))
        begin
            rd_entry = fwd_data_reg;
        end
        else if (valid_reg[rd_addr_reg])
        begin
            rd_entry = rdata_reg;
        end
        else
        begin
            rd_entry = zsdt_pkg::ENTRY_RESET;
        end
    end

    `ZSDT_ASSERT_SAME(a_wr_in_range, clk, rst_n, wr.en, (32'(wr_addr) < NUM_ZONES))
    `ZSDT_ASSERT_NEXT(a_wr_sets_valid, clk, rst_n, wr.en, valid_reg[$past(wr_addr)])
    `ZSDT_ASSERT_NEXT(a_fwd_tracks_wr, clk, rst_n, wr.en, fwd_en_reg && (fwd_data_reg == $past(wr.data)))

endmodule

### rtl/zone_state_debounce_table_unit.sv
// ----------------------------------------------------------------------------
// Zone state debounce table - top level
// Alarm zone table with debounced state confirmation and partition masks.
// ----------------------------------------------------------------------------
// Command channel: an item (cmd) is taken at a clock edge with start high and
// busy low. busy never rises, so one item may be issued every cycle.
// Result channel: done pulses for one cycle with the zone's contents on
// result; the receiver must take it then, there is no back-pressure.
// Path: the entry is read into a register at the edge that takes the item,
// together with the item itself; the update is worked out from them and lands
// in the output register together with done. Throughput: one item per cycle, set by
// the single read-modify-write on the zone memory; a write to the zone read
// in the same cycle is forwarded.
// Configuration: confirm_count at byte address 0 of the APB-style port;
// write it only while no item is in flight.
// Reset: every zone reads as unused with a countdown of 3, type 0 and empty
// mask, through per-zone valid bits; no clearing pass is needed, so items are
// taken straight after reset. confirm_count returns to 3.
// ----------------------------------------------------------------------------
`include "zone_state_debounce_table_unit_macros.svh"

module zone_state_debounce_table_unit #(
    parameter  int NUM_ZONES      = zsdt_pkg::NUM_ZONES_DEF,
    parameter  int NUM_PARTITIONS = zsdt_pkg::NUM_PARTITIONS_DEF,
    localparam int ZW             = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  zsdt_pkg::cmd_t    cmd,
    output logic              done,
    output zsdt_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic              accept;
    logic [7:0]        confirm_count;
    logic              s1_valid_reg;
    zsdt_pkg::cmd_t    s1_cmd_reg;
    zsdt_pkg::entry_t  rd_entry;
    zsdt_pkg::entry_t  upd;
    zsdt_pkg::wr_t     wr;
    logic              in_range;
    logic              part_ok;
    logic              changed;
    logic              done_reg;
    zsdt_pkg::result_t result_reg;
    zsdt_pkg::result_t result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    zsdt_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .confirm_count (confirm_count)
    );

    zsdt_table #(
        .NUM_ZONES (NUM_ZONES)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (ZW'(cmd.zone)),
        .wr       (wr),
        .wr_addr  (ZW'(s1_cmd_reg.zone)),
        .rd_entry (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd;
        end
        result_reg <= result_next;
    end

    assign in_range = 32'(s1_cmd_reg.zone) < NUM_ZONES;
    assign part_ok  = 32'(s1_cmd_reg.partition_index) < NUM_PARTITIONS;

    always_comb
    begin
        upd     = rd_entry;
        changed = 1'b0;
        unique case (s1_cmd_reg.op)
            zsdt_pkg::OP_OBSERVE:
            begin
                if ((rd_entry.cur != 3'd0) && (s1_cmd_reg.state_value != rd_entry.cur))
                begin
                    if (s1_cmd_reg.state_value == rd_entry.pend)
                    begin
                        if (rd_entry.count != 8'd0)
                        begin
                            upd.count = rd_entry.count - 8'd1;
                        end
                        else
                        begin
                            upd.cur = s1_cmd_reg.state_value;
                            changed = 1'b1;
                        end
                    end
                    else
                    begin
                        upd.pend  = s1_cmd_reg.state_value;
                        upd.count = confirm_count;
                    end
                end
            end
            zsdt_pkg::OP_LOAD:
            begin
                upd.cur   = 3'd0;
                upd.pend  = 3'd0;
                upd.count = confirm_count;
                upd.mask  = s1_cmd_reg.load_mask;
                upd.kind  = s1_cmd_reg.load_type;
            end
            zsdt_pkg::OP_SET_STATE:
            begin
                upd.cur = s1_cmd_reg.state_value;
            end
            zsdt_pkg::OP_PARTITION:
            begin
                if (part_ok)
                begin
                    upd.mask[s1_cmd_reg.partition_index] = s1_cmd_reg.member;
                end
            end
            default:
            begin
                upd = rd_entry;
            end
        endcase
    end

    assign wr.en   = s1_valid_reg && in_range;
    assign wr.data = upd;

    always_comb
    begin
        if (in_range)
        begin
            result_next.confirmed_state = upd.cur;
            result_next.zone_kind       = upd.kind;
            result_next.mask_out        = upd.mask;
            result_next.in_partition    = part_ok && upd.mask[s1_cmd_reg.partition_index];
            result_next.state_changed   = s1_valid_reg && changed;
        end
        else
        begin
            result_next = '0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ZSDT_ASSERT_NEXT(a_accept_stage, clk, rst_n, accept, s1_valid_reg)
    `ZSDT_ASSERT_NEXT(a_stage_done, clk, rst_n, s1_valid_reg, done)
    `ZSDT_ASSERT_SAME(a_changed_strobed, clk, rst_n, result.state_changed, done)

endmodule
